### src/positional_list_insert_delete_defines.svh
// ============================================================================
// positional_list_insert_delete_defines.svh
// Assertion macros shared by the checker of the positional list.
// ============================================================================
`ifndef POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PLI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define PLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/pli_pkg.sv
// ============================================================================
// pli_pkg
// Types and codes shared by the positional list modules.
// ============================================================================
package pli_pkg;

    // Width of positions and indexes carried to the cells (covers 0..127)
    localparam int CTL_W   = 7;
    localparam int POS_W   = 6;
    localparam int VALUE_W = 32;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_DUMP   = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_ROT
    } t_cell_op;

    // Broadcast control seen by every cell of the chain
    typedef struct packed {
        t_cell_op                   op;
        logic [CTL_W-1:0]           pos;    // insert/delete position
        logic [CTL_W-1:0]           tail;   // index of last entry, for rotate
        logic signed [VALUE_W-1:0]  value;  // value to insert
    } t_cell_ctl;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

endpackage

### src/pli_cell.sv
// ============================================================================
// pli_cell
// One list slot: holds an entry and takes its neighbor's on shifts.
// ============================================================================
module pli_cell (
    input  logic                               i_clk,
    input  pli_pkg::t_cell_ctl                 i_ctl,
    input  logic [pli_pkg::CTL_W-1:0]          i_index,
    input  logic signed [pli_pkg::VALUE_W-1:0] i_left,
    input  logic signed [pli_pkg::VALUE_W-1:0] i_right,
    input  logic signed [pli_pkg::VALUE_W-1:0] i_head,
    output logic signed [pli_pkg::VALUE_W-1:0] o_entry
);
    import pli_pkg::*;

    logic signed [VALUE_W-1:0] r_entry;
    logic signed [VALUE_W-1:0] n_entry;

    // Slot update: insert moves entries back, delete and rotate move them forward
    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            CELL_INS: begin
                if (i_index > i_ctl.pos) begin
                    n_entry = i_left;
                end else if (i_index == i_ctl.pos) begin
                    n_entry = i_ctl.value;
                end
            end
            CELL_DEL: begin
                if (i_index >= i_ctl.pos) begin
                    n_entry = i_right;
                end
            end
            CELL_ROT: begin
                if (i_index < i_ctl.tail) begin
                    n_entry = i_right;
                end else if (i_index == i_ctl.tail) begin
                    n_entry = i_head;
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

### src/positional_list_insert_delete.sv
// ============================================================================
// positional_list_insert_delete
// Ordered list of signed words changed by position, kept in a chain of cells.
// ============================================================================
// Channel   Dir  Payload                                    Handshake
// s_axis    in   tuser: mode; tdata: position, value        tvalid/tready
// m_axis    out  tuser: status; tdata: entry; tlast: last   tvalid/tready
//
// Insert and delete move all affected cells together in a single update.
// A dump of N entries emits one entry per cycle while the output is not stalled,
// by rotating the chain once through its head cell, and takes no request meanwhile.
// Reset clears the length, state, count and output valid; cell contents are undefined until written.
// A stalled output holds its result; no new request is taken until it drains.
module positional_list_insert_delete #(
    parameter int DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    input  logic [39:0] s_axis_tdata,   // [5:0] position, [37:6] value, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic [31:0] m_axis_tdata,   // [31:0] entry
    output logic        m_axis_tlast    // last result of the request
);
    import pli_pkg::*;

    localparam int LEN_W = $clog2(DEPTH + 1);

    // Control state
    t_state           r_state, n_state;
    logic [LEN_W-1:0] r_length, n_length;
    logic [LEN_W-1:0] r_cnt, n_cnt;

    // Request fields
    t_mode                     w_mode;
    logic [POS_W-1:0]          w_pos;
    logic signed [VALUE_W-1:0] w_value;
    logic [CTL_W-1:0]          w_pos_ext;
    logic [CTL_W-1:0]          w_len_ext;

    // Output register
    logic                      r_out_valid;
    t_status                   r_out_status;
    logic signed [VALUE_W-1:0] r_out_entry;
    logic                      r_out_last;

    logic                      w_out_free;
    logic                      w_accept;
    logic                      w_load;
    t_status                   w_status;
    logic signed [VALUE_W-1:0] w_entry_out;
    logic                      w_last_out;
    logic                      w_dump_last;
    t_cell_ctl                 w_ctl;

    logic signed [VALUE_W-1:0] w_cells [DEPTH];

    assign w_mode    = t_mode'(s_axis_tuser);
    assign w_pos     = s_axis_tdata[POS_W-1:0];
    assign w_value   = s_axis_tdata[POS_W+VALUE_W-1:POS_W];
    assign w_pos_ext = CTL_W'(w_pos);
    assign w_len_ext = CTL_W'(r_length);

    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_dump_last = (r_cnt == r_length - LEN_W'(1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_mode == MODE_DUMP && r_length != '0) begin
                    n_state = S_DUMP;
                end
            end
            S_DUMP: begin
                if (w_out_free && w_dump_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: result load, cell control, length and count
    always_comb begin
        s_axis_tready = 1'b0;
        w_load        = 1'b0;
        w_status      = ST_OK;
        w_entry_out   = '0;
        w_last_out    = 1'b1;
        n_length      = r_length;
        n_cnt         = r_cnt;
        w_ctl.op      = CELL_HOLD;
        w_ctl.pos     = w_pos_ext;
        w_ctl.tail    = w_len_ext - CTL_W'(1);
        w_ctl.value   = w_value;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = w_out_free;
                n_cnt         = '0;
                if (w_accept) begin
                    case (w_mode)
                        MODE_INSERT: begin
                            w_load = 1'b1;
                            if (w_pos_ext > w_len_ext) begin
                                w_status = ST_BAD_POS;
                            end else if (r_length == LEN_W'(DEPTH)) begin
                                w_status = ST_FULL;
                            end else begin
                                w_ctl.op = CELL_INS;
                                n_length = r_length + LEN_W'(1);
                            end
                        end
                        MODE_DELETE: begin
                            w_load = 1'b1;
                            if (w_pos_ext >= w_len_ext) begin
                                w_status = ST_BAD_POS;
                            end else begin
                                w_ctl.op = CELL_DEL;
                                n_length = r_length - LEN_W'(1);
                            end
                        end
                        MODE_DUMP: begin
                            // an empty list answers at once; otherwise the run starts
                            if (r_length == '0) begin
                                w_load   = 1'b1;
                                w_status = ST_EMPTY;
                            end
                        end
                        default: w_load = 1'b0;
                    endcase
                end
            end
            S_DUMP: begin
                if (w_out_free) begin
                    w_load      = 1'b1;
                    w_entry_out = w_cells[0];
                    w_last_out  = w_dump_last;
                    w_ctl.op    = CELL_ROT;
                    n_cnt       = r_cnt + LEN_W'(1);
                end
            end
            default: s_axis_tready = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_length    <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_length <= n_length;
            r_cnt    <= n_cnt;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_status <= w_status;
            r_out_entry  <= w_entry_out;
            r_out_last   <= w_last_out;
        end
    end

    // Chain of cells; ends see zero neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [VALUE_W-1:0] w_left;
        logic signed [VALUE_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cells[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cells[g+1];
        end
        pli_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_index (CTL_W'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_cells[0]),
            .o_entry (w_cells[g])
        );
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = r_out_entry;
    assign m_axis_tlast  = r_out_last;

endmodule

### src/pli_checker.sv
// ============================================================================
// pli_checker
// Port-level checks of the positional list, bound to the top level.
// ============================================================================
`include "positional_list_insert_delete_defines.svh"

module pli_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [1:0]  m_axis_tuser,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    import pli_pkg::*;

    // A stalled result keeps its payload
    `PLI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // No request is taken while a dump run is still going
    `PLI_ASSERT_NOW(a_dump_blocks, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "request taken during dump")

    // Any status other than ok ends its request and carries no entry
    `PLI_ASSERT_NOW(a_err_single, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tlast && m_axis_tdata == 32'd0, "error result malformed")

    // An insert or delete answers in the next cycle with a single result
    `PLI_ASSERT_NEXT(a_edit_reply, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_INSERT || s_axis_tuser == MODE_DELETE), m_axis_tvalid && m_axis_tlast && m_axis_tdata == 32'd0, "edit result missing")

endmodule

bind positional_list_insert_delete pli_checker u_pli_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Positional list regression
// Drives insert, delete, dump and ignored requests into the list over the
// input stream. A local copy of the list predicts every status and dumped
// entry, and each result from the output stream is checked in order against
// it. Both stream sides idle at random, and the receiver holds off for a
// long stretch once so that the list fills its output and stalls its input.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pli_pkg::*;

    localparam int LIST_DEPTH       = 32;
    localparam int SINK_HOLD_CYCLES = 90;
    localparam int DRAIN_CYCLES     = 2 * LIST_DEPTH + 10;

    typedef struct {
        t_status            status;
        logic signed [31:0] entry;
        logic               last;
    } t_list_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [1:0]  s_axis_tuser;   // [1:0] mode
    logic [39:0] s_axis_tdata;   // [5:0] position, [37:6] value, zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [1:0]  m_axis_tuser;   // [1:0] status
    logic [31:0] m_axis_tdata;   // [31:0] entry
    logic        m_axis_tlast;

    // Local copy of the list and the replies it predicts, oldest first
    logic signed [31:0] list_copy[$];
    t_list_reply        due_replies[$];

    // Length as seen by the request generator (updated on acceptance)
    int sent_len;
    int peak_len;
    int n_errors;
    int n_replies_checked;
    int n_req_by_mode[4];
    int n_rejects[4];

    bit src_gaps_on;
    bit sink_stalls_on;
    bit sink_hold_req;

    positional_list_insert_delete #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("positional_list_insert_delete regression: fail");
        $finish;
    end

    // Apply one accepted request to the list copy and queue its replies
    function automatic void apply_list_op(t_mode mode, logic [5:0] pos,
                                          logic signed [31:0] val);
        t_list_reply rep;
        int          len;
        len = list_copy.size();
        rep.status = ST_OK;
        rep.entry  = '0;
        rep.last   = 1'b1;
        n_req_by_mode[mode]++;
        case (mode)
            MODE_INSERT: begin
                if (pos > len) begin
                    rep.status = ST_BAD_POS;
                end else if (len >= LIST_DEPTH) begin
                    rep.status = ST_FULL;
                end else begin
                    list_copy.insert(int'(pos), val);
                end
                due_replies.push_back(rep);
            end
            MODE_DELETE: begin
                if (pos >= len) begin
                    rep.status = ST_BAD_POS;
                end else begin
                    list_copy.delete(int'(pos));
                end
                due_replies.push_back(rep);
            end
            MODE_DUMP: begin
                if (len == 0) begin
                    rep.status = ST_EMPTY;
                    due_replies.push_back(rep);
                end else begin
                    for (int i = 0; i < len; i++) begin
                        rep.entry = list_copy[i];
                        rep.last  = (i == len - 1);
                        due_replies.push_back(rep);
                    end
                end
            end
            default: ;  // ignored request
        endcase
        if (mode != MODE_DUMP && rep.status != ST_OK)
            n_rejects[rep.status]++;
        if (list_copy.size() > peak_len)
            peak_len = list_copy.size();
    endfunction

    // Compare one delivered result with the oldest predicted reply
    function automatic void check_reply();
        t_list_reply rep;
        if (due_replies.size() == 0) begin
            $error("unexpected result: status %0d entry %0d last %0d",
                   m_axis_tuser, $signed(m_axis_tdata), m_axis_tlast);
            n_errors++;
            return;
        end
        rep = due_replies.pop_front();
        n_replies_checked++;
        if (m_axis_tuser !== rep.status) begin
            $error("status mismatch: expected %0d, got %0d", rep.status, m_axis_tuser);
            n_errors++;
        end
        if (m_axis_tdata !== rep.entry) begin
            $error("entry mismatch: expected %0d, got %0d",
                   rep.entry, $signed(m_axis_tdata));
            n_errors++;
        end
        if (m_axis_tlast !== rep.last) begin
            $error("last mismatch: expected %0d, got %0d", rep.last, m_axis_tlast);
            n_errors++;
        end
    endfunction

    // Monitor both streams; requests are predicted before results are checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                apply_list_op(t_mode'(s_axis_tuser), s_axis_tdata[5:0],
                              s_axis_tdata[37:6]);
            if (m_axis_tvalid && m_axis_tready)
                check_reply();
        end
    end

    // Receiver: random stall bursts, plus one long counted hold on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
                sink_hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one request and hold it until the list takes it
    task automatic send_request(t_mode mode, logic [5:0] pos, logic signed [31:0] val);
        if (src_gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {2'b00, val, pos};
        do @(posedge i_clk); while (!s_axis_tready);
        if (mode == MODE_INSERT && pos <= sent_len && sent_len < LIST_DEPTH)
            sent_len++;
        else if (mode == MODE_DELETE && pos < sent_len)
            sent_len--;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly in-range positions, sometimes anything the field can carry
    function automatic logic [5:0] pick_position(t_mode mode);
        if ($urandom_range(0, 99) < 15)
            return 6'($urandom_range(0, 63));
        if (mode == MODE_INSERT)
            return 6'($urandom_range(0, sent_len));
        if (sent_len == 0)
            return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, sent_len - 1));
    endfunction

    // Extremes of every field and each corner named by the list rules
    task automatic test_directed_edges();
        send_request(MODE_DUMP,   6'd0,  32'sd0);          // dump of empty list
        send_request(MODE_DELETE, 6'd0,  32'sd0);          // delete on empty list
        send_request(MODE_INSERT, 6'd1,  32'sd5);          // insert past the end
        send_request(MODE_INSERT, 6'd63, 32'sh7fff_ffff);  // far out of range
        send_request(MODE_INSERT, 6'd0,  32'sh8000_0000);
        send_request(MODE_INSERT, 6'd1,  32'sh7fff_ffff);  // append at the end
        send_request(MODE_INSERT, 6'd1,  -32'sd1);         // middle
        send_request(MODE_INSERT, 6'd0,  32'sd0);          // head
        send_request(MODE_NOP,    6'd63, 32'shffff_ffff);  // ignored
        send_request(MODE_DUMP,   6'd63, 32'shffff_ffff);
        send_request(MODE_DELETE, 6'd4,  32'sd0);          // position == length
        send_request(MODE_DELETE, 6'd63, 32'sd0);
        send_request(MODE_DELETE, 6'd1,  32'sd0);
        send_request(MODE_DELETE, 6'd2,  32'sd0);          // tail
        send_request(MODE_INSERT, 6'd2,  32'sh5555_5555);
        send_request(MODE_NOP,    6'd0,  32'sd0);
        send_request(MODE_DUMP,   6'd0,  32'sd0);
    endtask

    // Fill to capacity, hit the full and position checks, dump, then empty it
    task automatic test_fill_and_drain();
        while (sent_len < LIST_DEPTH)
            send_request(MODE_INSERT, 6'($urandom_range(0, sent_len)), pick_value());
        send_request(MODE_INSERT, 6'(LIST_DEPTH), pick_value());  // full, valid position
        send_request(MODE_INSERT, 6'($urandom_range(0, LIST_DEPTH - 1)), pick_value());
        send_request(MODE_INSERT, 6'(LIST_DEPTH + 1), pick_value());  // position check first
        send_request(MODE_DUMP, 6'd0, 32'sd0);                    // longest dump
        send_request(MODE_DELETE, 6'(LIST_DEPTH), 32'sd0);
        while (sent_len > 0)
            send_request(MODE_DELETE, 6'($urandom_range(0, sent_len - 1)), $urandom);
        send_request(MODE_DUMP, 6'd0, 32'sd0);
    endtask

    // Receiver holds off while the sender keeps offering requests
    task automatic test_back_pressure();
        sink_hold_req = 1'b1;
        repeat (6) send_request(MODE_INSERT, pick_position(MODE_INSERT), pick_value());
        repeat (3) send_request(MODE_DUMP, 6'($urandom), $urandom);
        repeat (3) send_request(MODE_DELETE, pick_position(MODE_DELETE), $urandom);
        send_request(MODE_DUMP, 6'd0, 32'sd0);
    endtask

    // Weighted random operations with random content
    task automatic test_random_mix(int count);
        t_mode mode;
        int    r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 10 + (LIST_DEPTH - sent_len))
                mode = MODE_INSERT;
            else if (r < 82)
                mode = MODE_DELETE;
            else if (r < 95)
                mode = MODE_DUMP;
            else
                mode = MODE_NOP;
            send_request(mode, pick_position(mode), pick_value());
        end
    endtask

    // Stimulus
    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tuser   = MODE_NOP;
        s_axis_tdata   = '0;
        sent_len       = 0;
        peak_len       = 0;
        n_errors       = 0;
        n_replies_checked = 0;
        n_req_by_mode  = '{default: 0};
        n_rejects      = '{default: 0};
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        sink_hold_req  = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_fill_and_drain();
        test_back_pressure();
        test_random_mix(55);

        // Last stretch runs with no idling on either side
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        test_random_mix(30);

        s_axis_tvalid <= 1'b0;
        while (due_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Requests: %0d insert, %0d delete, %0d dump, %0d ignored; %0d results checked",
                 n_req_by_mode[MODE_INSERT], n_req_by_mode[MODE_DELETE],
                 n_req_by_mode[MODE_DUMP], n_req_by_mode[MODE_NOP], n_replies_checked);
        $display("Rejects: %0d bad position, %0d list full; list peaked at %0d entries",
                 n_rejects[ST_BAD_POS], n_rejects[ST_FULL], peak_len);
        if (n_errors == 0)
            $display("positional_list_insert_delete regression: pass");
        else
            $display("positional_list_insert_delete regression: fail");
        $finish;
    end

endmodule
